>>> src/bmseq_pkg.sv
// Package for the buzzer melody sequencer: item codes, note codes, melody ROM
// contents and the per-note period and scale tables.
// No dependencies.
package bmseq_pkg;

   localparam int SLOTS_PER_MELODY = 9;
   localparam int MELODY_COUNT     = 10;
   localparam int SLOT_CAP         = (SLOTS_PER_MELODY > 15) ? 15 : SLOTS_PER_MELODY;

   localparam int MODE_W   = 2;
   localparam int MELODY_W = 4;
   localparam int SLOT_W   = 4;
   localparam int TOP_W    = 11;
   localparam int CMP_W    = 10;
   localparam int TICK_W   = 7;
   localparam int DUR_W    = 5;
   localparam int SCALE_W  = 11;
   localparam int PROD_W   = SCALE_W + DUR_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK = 2'd0,
      MODE_PLAY = 2'd1,
      MODE_READ = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      NOTE_X = 4'd0,
      NOTE_C = 4'd1,
      NOTE_D = 4'd2,
      NOTE_E = 4'd3,
      NOTE_F = 4'd4,
      NOTE_G = 4'd5,
      NOTE_A = 4'd6,
      NOTE_B = 4'd7,
      NOTE_O = 4'd8
   } note_code_type;

   // tone settings loaded by a play item
   typedef struct packed {
      logic              row_valid;
      logic [TOP_W-1:0]  top;
      logic [CMP_W-1:0]  compare;
      logic [TICK_W-1:0] length;
   } note_type;

   localparam note_code_type NOTE_ROM [MELODY_COUNT][SLOTS_PER_MELODY] = '{
      '{NOTE_X, NOTE_C, NOTE_G, NOTE_G, NOTE_A, NOTE_G, NOTE_X, NOTE_B, NOTE_C},
      '{NOTE_X, NOTE_C, NOTE_B, NOTE_A, NOTE_G, NOTE_X, NOTE_X, NOTE_X, NOTE_X},
      '{NOTE_X, NOTE_B, NOTE_B, NOTE_B, NOTE_B, NOTE_B, NOTE_X, NOTE_X, NOTE_X},
      '{NOTE_X, NOTE_C, NOTE_D, NOTE_E, NOTE_C, NOTE_X, NOTE_X, NOTE_X, NOTE_X},
      '{NOTE_X, NOTE_C, NOTE_C, NOTE_C, NOTE_D, NOTE_E, NOTE_X, NOTE_X, NOTE_X},
      '{NOTE_X, NOTE_C, NOTE_C, NOTE_C, NOTE_D, NOTE_E, NOTE_X, NOTE_X, NOTE_X},
      '{NOTE_X, NOTE_A, NOTE_X, NOTE_E, NOTE_X, NOTE_A, NOTE_X, NOTE_E, NOTE_X},
      '{NOTE_X, NOTE_E, NOTE_D, NOTE_C, NOTE_B, NOTE_A, NOTE_X, NOTE_X, NOTE_X},
      '{NOTE_X, NOTE_E, NOTE_D, NOTE_C, NOTE_B, NOTE_A, NOTE_X, NOTE_X, NOTE_X},
      '{NOTE_X, NOTE_A, NOTE_C, NOTE_E, NOTE_X, NOTE_X, NOTE_X, NOTE_X, NOTE_X}
   };

   localparam logic [DUR_W-1:0] DUR_ROM [MELODY_COUNT][SLOTS_PER_MELODY] = '{
      '{5'd0, 5'd20, 5'd10, 5'd10, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20},
      '{5'd0, 5'd20, 5'd10, 5'd10, 5'd20, 5'd0,  5'd0,  5'd0,  5'd0},
      '{5'd0, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd0,  5'd0,  5'd0},
      '{5'd0, 5'd20, 5'd20, 5'd20, 5'd20, 5'd0,  5'd0,  5'd0,  5'd0},
      '{5'd0, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd0,  5'd0,  5'd0},
      '{5'd0, 5'd20, 5'd20, 5'd20, 5'd20, 5'd20, 5'd0,  5'd0,  5'd0},
      '{5'd0, 5'd20, 5'd20, 5'd20, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
      '{5'd0, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd0},
      '{5'd0, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd0},
      '{5'd0, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd0,  5'd0,  5'd0}
   };

   function automatic logic [TOP_W-1:0] note_top(note_code_type code);
      logic [TOP_W-1:0] t;
      unique case (code)
         NOTE_C:  t = 11'd953;
         NOTE_D:  t = 11'd841;
         NOTE_E:  t = 11'd757;
         NOTE_F:  t = 11'd709;
         NOTE_G:  t = 11'd1275;
         NOTE_A:  t = 11'd1135;
         NOTE_B:  t = 11'd1011;
         NOTE_O:  t = 11'd1249;
         default: t = 11'd1;
      endcase
      return t;
   endfunction

   function automatic logic [SCALE_W-1:0] note_scale(note_code_type code);
      logic [SCALE_W-1:0] s;
      unique case (code)
         NOTE_C:  s = 11'd666;
         NOTE_D:  s = 11'd768;
         NOTE_E:  s = 11'd845;
         NOTE_F:  s = 11'd896;
         NOTE_G:  s = 11'd1024;
         NOTE_A:  s = 11'd1126;
         NOTE_B:  s = 11'd1254;
         NOTE_O:  s = 11'd512;
         default: s = 11'd0;
      endcase
      return s;
   endfunction

endpackage

>>> src/bmseq_note_rom.sv
// Melody ROM lookup: note at (melody, slot) turned into PWM top, compare
// and tone length. Depends on bmseq_pkg.
module bmseq_note_rom (
   input  logic [bmseq_pkg::MELODY_W-1:0] melody,
   input  logic [bmseq_pkg::SLOT_W-1:0]   slot,
   output bmseq_pkg::note_type            note
);

   bmseq_pkg::note_code_type       code;
   logic [bmseq_pkg::DUR_W-1:0]    dur;
   logic [bmseq_pkg::PROD_W-1:0]   prod;
   logic                           row_ok;
   logic                           col_ok;

   assign row_ok = ({1'b0, melody} < (bmseq_pkg::MELODY_W+1)'(bmseq_pkg::MELODY_COUNT));
   assign col_ok = ({1'b0, slot} < (bmseq_pkg::SLOT_W+1)'(bmseq_pkg::SLOT_CAP));

   always_comb begin
      code = bmseq_pkg::NOTE_X;
      dur  = '0;
      if (row_ok && col_ok) begin
         code = bmseq_pkg::NOTE_ROM[melody][slot];
         dur  = bmseq_pkg::DUR_ROM[melody][slot];
      end
   end

   assign prod = bmseq_pkg::PROD_W'(bmseq_pkg::note_scale(code))
               * bmseq_pkg::PROD_W'(dur);

   always_comb begin
      note.row_valid = row_ok;
      note.top       = bmseq_pkg::note_top(code);
      // rest and empty slots stay silent
      if (code == bmseq_pkg::NOTE_O || code == bmseq_pkg::NOTE_X) begin
         note.compare = '0;
      end else begin
         note.compare = bmseq_pkg::CMP_W'(note.top >> 1);
      end
      note.length = prod[8 +: bmseq_pkg::TICK_W];
   end

endmodule

>>> src/buzzer_melody_sequencer.sv
// Buzzer melody sequencer top level: input register, tone state update and
// result register. Depends on bmseq_pkg and bmseq_note_rom.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  req     | req_valid/stall    | req_mode, req_melody
//  rsp     | rsp_valid/stall    | rsp_pwm_top, rsp_pwm_compare,
//          |                    | rsp_tone_active, rsp_position
//  csr     | csr_valid/ready    | csr_max_notes
//
// One item per cycle sustained while the result is not stalled; each accepted
// item passes the input register, then ROM lookup and state update into the
// result register. Reset is synchronous and returns the tone to silent,
// the slot to 0 and max_notes to 8. A stalled result holds the result
// register; the input register still takes one item while it is empty, then
// the input stalls until the result drains.
module buzzer_melody_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bmseq_pkg::MODE_W-1:0]     req_mode,
   input  logic [bmseq_pkg::MELODY_W-1:0]   req_melody,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bmseq_pkg::TOP_W-1:0]      rsp_pwm_top,
   output logic [bmseq_pkg::CMP_W-1:0]      rsp_pwm_compare,
   output logic                             rsp_tone_active,
   output logic [bmseq_pkg::SLOT_W-1:0]     rsp_position,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bmseq_pkg::SLOT_W-1:0]     csr_max_notes
);

   // input stage
   logic                               in_vld_ff;
   logic [bmseq_pkg::MODE_W-1:0]       mode_ff;
   logic [bmseq_pkg::MELODY_W-1:0]     melody_ff;

   // tone state
   logic [bmseq_pkg::SLOT_W-1:0]       max_notes_ff;
   logic [bmseq_pkg::TOP_W-1:0]        top_ff, top_in;
   logic [bmseq_pkg::CMP_W-1:0]        cmp_ff, cmp_in;
   logic                               playing_ff, playing_in;
   logic [bmseq_pkg::TICK_W-1:0]       elapsed_ff, elapsed_in;
   logic [bmseq_pkg::TICK_W-1:0]       target_ff, target_in;
   logic [bmseq_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   logic [bmseq_pkg::SLOT_W-1:0]       pos_in;

   // result stage
   logic                               out_vld_ff;
   logic [bmseq_pkg::TOP_W-1:0]        out_top_ff;
   logic [bmseq_pkg::CMP_W-1:0]        out_cmp_ff;
   logic                               out_act_ff;
   logic [bmseq_pkg::SLOT_W-1:0]       out_pos_ff;

   logic                               advance;
   logic                               load_in;
   logic [bmseq_pkg::TICK_W-1:0]       elapsed_inc;
   bmseq_pkg::note_type                note;

   assign advance   = !out_vld_ff || !rsp_stall;
   // an empty input register takes an item even while the result is held
   assign load_in   = advance || !in_vld_ff;
   assign req_stall = !load_in;
   assign csr_ready = 1'b1;

   bmseq_note_rom u_rom (
      .melody (melody_ff),
      .slot   (slot_ff),
      .note   (note)
   );

   assign elapsed_inc = elapsed_ff + 1'b1;

   always_comb begin
      top_in     = top_ff;
      cmp_in     = cmp_ff;
      playing_in = playing_ff;
      elapsed_in = elapsed_ff;
      target_in  = target_ff;
      slot_in    = slot_ff;
      pos_in     = slot_ff;
      unique case (mode_ff)
         bmseq_pkg::MODE_TICK: begin
            if (playing_ff) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= target_ff) begin
                  top_in     = 11'd1;
                  cmp_in     = '0;
                  playing_in = 1'b0;
                  elapsed_in = '0;
                  target_in  = '0;
               end
            end
         end
         bmseq_pkg::MODE_PLAY: begin
            if (note.row_valid) begin
               top_in     = note.top;
               cmp_in     = note.compare;
               target_in  = note.length;
               playing_in = 1'b1;
            end
            if ({1'b0, slot_ff} < (bmseq_pkg::SLOT_W+1)'(bmseq_pkg::SLOT_CAP)) begin
               slot_in = slot_ff + 1'b1;
            end
            pos_in = slot_in;
         end
         bmseq_pkg::MODE_READ: begin
            if (slot_ff >= max_notes_ff) begin
               slot_in = '0;
               pos_in  = max_notes_ff;
            end
         end
         default: begin
            pos_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         max_notes_ff <= 4'd8;
         top_ff       <= 11'd1;
         cmp_ff       <= '0;
         playing_ff   <= 1'b0;
         elapsed_ff   <= '0;
         target_ff    <= '0;
         slot_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_notes_ff <= csr_max_notes;
         end
         if (load_in) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            out_vld_ff <= in_vld_ff;
            if (in_vld_ff) begin
               top_ff     <= top_in;
               cmp_ff     <= cmp_in;
               playing_ff <= playing_in;
               elapsed_ff <= elapsed_in;
               target_ff  <= target_in;
               slot_ff    <= slot_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         mode_ff   <= req_mode;
         melody_ff <= req_melody;
      end
      if (advance) begin
         if (in_vld_ff) begin
            out_top_ff <= top_in;
            out_cmp_ff <= cmp_in;
            out_act_ff <= playing_in;
            out_pos_ff <= pos_in;
         end
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_pwm_top     = out_top_ff;
   assign rsp_pwm_compare = out_cmp_ff;
   assign rsp_tone_active = out_act_ff;
   assign rsp_position    = out_pos_ff;

endmodule

>>> tb/sv/buzzer_melody_sequencer_test.sv
// Self-checking testbench for buzzer_melody_sequencer: a queue-fed driver, a
// stalling monitor and a per-item predictor of tone and slot state.
// Depends on bmseq_pkg and the buzzer_melody_sequencer RTL.
module buzzer_melody_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_MELODIES = 10;
   localparam int NUM_SLOTS    = 9;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 150;
   localparam int PRINT_CAP    = 100;
   localparam logic [bmseq_pkg::MODE_W-1:0] MODE_UNDEFINED = 2'd3;

   typedef enum logic [3:0] {
      TN_X, TN_C, TN_D, TN_E, TN_F, TN_G, TN_A, TN_B, TN_O
   } tone_type;

   typedef struct packed {
      logic [bmseq_pkg::MODE_W-1:0]   mode;
      logic [bmseq_pkg::MELODY_W-1:0] melody;
   } note_cmd_type;

   typedef struct packed {
      logic [bmseq_pkg::TOP_W-1:0]  top;
      logic [bmseq_pkg::CMP_W-1:0]  compare;
      logic                         active;
      logic [bmseq_pkg::SLOT_W-1:0] position;
   } tone_status_type;

   localparam int TONE_PERIOD [9] = '{1, 953, 841, 757, 709, 1275, 1135, 1011, 1249};
   localparam int TONE_SCALE  [9] = '{0, 666, 768, 845, 896, 1024, 1126, 1254, 512};

   localparam tone_type SONG_NOTES [NUM_MELODIES][NUM_SLOTS] = '{
      '{TN_X, TN_C, TN_G, TN_G, TN_A, TN_G, TN_X, TN_B, TN_C},
      '{TN_X, TN_C, TN_B, TN_A, TN_G, TN_X, TN_X, TN_X, TN_X},
      '{TN_X, TN_B, TN_B, TN_B, TN_B, TN_B, TN_X, TN_X, TN_X},
      '{TN_X, TN_C, TN_D, TN_E, TN_C, TN_X, TN_X, TN_X, TN_X},
      '{TN_X, TN_C, TN_C, TN_C, TN_D, TN_E, TN_X, TN_X, TN_X},
      '{TN_X, TN_C, TN_C, TN_C, TN_D, TN_E, TN_X, TN_X, TN_X},
      '{TN_X, TN_A, TN_X, TN_E, TN_X, TN_A, TN_X, TN_E, TN_X},
      '{TN_X, TN_E, TN_D, TN_C, TN_B, TN_A, TN_X, TN_X, TN_X},
      '{TN_X, TN_E, TN_D, TN_C, TN_B, TN_A, TN_X, TN_X, TN_X},
      '{TN_X, TN_A, TN_C, TN_E, TN_X, TN_X, TN_X, TN_X, TN_X}
   };

   localparam int SONG_LEN [NUM_MELODIES][NUM_SLOTS] = '{
      '{0, 20, 10, 10, 20, 20, 20, 20, 20},
      '{0, 20, 10, 10, 20,  0,  0,  0,  0},
      '{0, 10, 10, 10, 10, 10,  0,  0,  0},
      '{0, 20, 20, 20, 20,  0,  0,  0,  0},
      '{0, 20, 20, 20, 20, 20,  0,  0,  0},
      '{0, 20, 20, 20, 20, 20,  0,  0,  0},
      '{0, 20, 20, 20,  0,  0,  0,  0,  0},
      '{0, 10, 10, 10, 10, 10, 10, 10,  0},
      '{0, 10, 10, 10, 10, 10, 10, 10,  0},
      '{0, 10, 10, 10, 10, 10,  0,  0,  0}
   };

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [bmseq_pkg::MODE_W-1:0]     req_mode = '0;
   logic [bmseq_pkg::MELODY_W-1:0]   req_melody = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [bmseq_pkg::TOP_W-1:0]      rsp_pwm_top;
   logic [bmseq_pkg::CMP_W-1:0]      rsp_pwm_compare;
   logic                             rsp_tone_active;
   logic [bmseq_pkg::SLOT_W-1:0]     rsp_position;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [bmseq_pkg::SLOT_W-1:0]     csr_max_notes = '0;

   // predicted sequencer state
   logic [bmseq_pkg::SLOT_W-1:0] max_notes_cfg = 4'd8;
   logic [bmseq_pkg::TOP_W-1:0]  sq_top = 11'd1;
   logic [bmseq_pkg::CMP_W-1:0]  sq_compare = '0;
   logic                         sq_playing = 1'b0;
   logic [6:0]                   sq_elapsed = '0;
   logic [6:0]                   sq_target = '0;
   logic [bmseq_pkg::SLOT_W-1:0] sq_slot = '0;

   note_cmd_type    note_cmds[$];
   tone_status_type expected_tones[$];
   int              cmds_queued = 0;
   int              cmds_accepted = 0;
   int              results_checked = 0;
   int              error_count = 0;
   int              cycle_count = 0;
   int              burst_left = 1;
   int              gap_left = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;
   int              stall_style = 0;
   int              stall_phase = 0;

   buzzer_melody_sequencer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_melody      (req_melody),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pwm_top     (rsp_pwm_top),
      .rsp_pwm_compare (rsp_pwm_compare),
      .rsp_tone_active (rsp_tone_active),
      .rsp_position    (rsp_position),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_max_notes   (csr_max_notes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic tone_status_type advance_sequencer(
      logic [bmseq_pkg::MODE_W-1:0]   mode,
      logic [bmseq_pkg::MELODY_W-1:0] melody
   );
      tone_status_type res;
      tone_type        code;
      int              length;
      int              prod;
      res.position = sq_slot;
      case (mode)
         bmseq_pkg::MODE_TICK: begin
            if (sq_playing) begin
               sq_elapsed = sq_elapsed + 7'd1;
               if (sq_elapsed >= sq_target) begin
                  sq_top = 11'd1;
                  sq_compare = '0;
                  sq_playing = 1'b0;
                  sq_elapsed = '0;
                  sq_target = '0;
               end
            end
            res.position = sq_slot;
         end
         bmseq_pkg::MODE_PLAY: begin
            // out-of-range melody keeps the tone but still moves the slot
            if (melody < NUM_MELODIES) begin
               code = TN_X;
               length = 0;
               if (sq_slot < NUM_SLOTS) begin
                  code = SONG_NOTES[melody][sq_slot];
                  length = SONG_LEN[melody][sq_slot];
               end
               if (code == TN_X) begin
                  sq_top = 11'd1;
                  sq_compare = '0;
                  sq_target = '0;
               end else begin
                  sq_top = bmseq_pkg::TOP_W'(TONE_PERIOD[code]);
                  sq_compare = (code == TN_O) ? '0 : bmseq_pkg::CMP_W'(sq_top >> 1);
                  prod = (TONE_SCALE[code] * length) >> 8;
                  sq_target = prod[6:0];
               end
               sq_playing = 1'b1;
            end
            if (sq_slot < NUM_SLOTS)
               sq_slot = sq_slot + 1'b1;
            res.position = sq_slot;
         end
         bmseq_pkg::MODE_READ: begin
            if (sq_slot < max_notes_cfg) begin
               res.position = sq_slot;
            end else begin
               sq_slot = '0;
               res.position = max_notes_cfg;
            end
         end
         default: res.position = sq_slot;
      endcase
      res.top = sq_top;
      res.compare = sq_compare;
      res.active = sq_playing;
      return res;
   endfunction

   task automatic report_mismatch(string what);
      if (error_count < PRINT_CAP)
         $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic queue_cmd(logic [bmseq_pkg::MODE_W-1:0] mode,
                            logic [bmseq_pkg::MELODY_W-1:0] melody);
      note_cmd_type cmd;
      cmd.mode = mode;
      cmd.melody = melody;
      note_cmds.push_back(cmd);
      cmds_queued++;
   endtask

   // mostly play-then-ring sequences, with reads and random noise mixed in
   task automatic fill_random(int count);
      int n;
      int r;
      int ring;
      n = 0;
      while (n < count) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            queue_cmd(bmseq_pkg::MODE_W'($urandom_range(0, 3)),
                      bmseq_pkg::MELODY_W'($urandom_range(0, 15)));
            n++;
         end else if (r < 22) begin
            queue_cmd(bmseq_pkg::MODE_READ, bmseq_pkg::MELODY_W'($urandom_range(0, 15)));
            n++;
         end else begin
            if ($urandom_range(0, 9) == 0)
               queue_cmd(bmseq_pkg::MODE_PLAY, bmseq_pkg::MELODY_W'($urandom_range(10, 15)));
            else
               queue_cmd(bmseq_pkg::MODE_PLAY, bmseq_pkg::MELODY_W'($urandom_range(0, 9)));
            n++;
            r = $urandom_range(0, 9);
            if (r < 4)
               ring = $urandom_range(0, 2);
            else if (r < 7)
               ring = $urandom_range(3, 30);
            else
               ring = $urandom_range(30, 100);
            repeat (ring) begin
               queue_cmd(bmseq_pkg::MODE_TICK, bmseq_pkg::MELODY_W'($urandom_range(0, 15)));
               n++;
            end
         end
      end
   endtask

   task automatic wait_idle();
      while (cmds_accepted != cmds_queued || expected_tones.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_notes(logic [bmseq_pkg::SLOT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_max_notes <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      max_notes_cfg = value;
   endtask

   always @(posedge clock) begin : note_driver
      note_cmd_type cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_tones.push_back(advance_sequencer(req_mode, req_melody));
            cmds_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (note_cmds.size() > 0) begin
               cmd = note_cmds.pop_front();
               req_valid <= 1'b1;
               req_mode <= cmd.mode;
               req_melody <= cmd.melody;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : tone_monitor
      tone_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_tones.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_tones.pop_front();
            if (rsp_pwm_top !== want.top)
               report_mismatch($sformatf("pwm_top %0d, expected %0d", rsp_pwm_top, want.top));
            if (rsp_pwm_compare !== want.compare)
               report_mismatch($sformatf("pwm_compare %0d, expected %0d",
                                         rsp_pwm_compare, want.compare));
            if (rsp_tone_active !== want.active)
               report_mismatch($sformatf("tone_active %0b, expected %0b",
                                         rsp_tone_active, want.active));
            if (rsp_position !== want.position)
               report_mismatch($sformatf("position %0d, expected %0d",
                                         rsp_position, want.position));
         end
      end

      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_checked >= 300 && note_cmds.size() > 20) begin
         // long back-pressure so the pipeline fills and stalls the input
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         stall_phase++;
         if (stall_phase >= 100) begin
            stall_phase = 0;
            stall_style = $urandom_range(0, 3);
         end
         case (stall_style)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [bmseq_pkg::SLOT_W-1:0] settings[6];
      settings = '{4'd0, 4'd15, 4'd1, 4'd4, 4'd8, 4'd0};
      settings[5] = bmseq_pkg::SLOT_W'($urandom_range(1, 8));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk through several melodies with max_notes at its reset value
      queue_cmd(bmseq_pkg::MODE_TICK, 4'd0);    // tick while silent
      queue_cmd(MODE_UNDEFINED, 4'd5);
      queue_cmd(bmseq_pkg::MODE_READ, 4'd0);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd0);    // empty slot still sets playing
      queue_cmd(bmseq_pkg::MODE_TICK, 4'd15);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd15);   // melody out of range
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd10);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd9);
      queue_cmd(bmseq_pkg::MODE_TICK, 4'd0);
      queue_cmd(bmseq_pkg::MODE_TICK, 4'd0);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd6);    // empty note over a running count
      queue_cmd(bmseq_pkg::MODE_TICK, 4'd0);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd2);
      queue_cmd(MODE_UNDEFINED, 4'd15);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd7);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd0);    // longest note
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd0);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd1);    // slot saturated past the melody
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd4);
      queue_cmd(bmseq_pkg::MODE_READ, 4'd3);    // wraps the slot
      queue_cmd(bmseq_pkg::MODE_READ, 4'd0);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd8);
      queue_cmd(bmseq_pkg::MODE_PLAY, 4'd5);
      queue_cmd(bmseq_pkg::MODE_TICK, 4'd0);
      fill_random(150);
      wait_idle();

      foreach (settings[i]) begin
         write_max_notes(settings[i]);
         fill_random(120);
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
src/bmseq_pkg.sv
src/bmseq_note_rom.sv
src/buzzer_melody_sequencer.sv
tb/sv/buzzer_melody_sequencer_test.sv
